// File: src/ue_context_control_table_defines.svh
// Assertion macros used by the top-level file.
`ifndef UE_CONTEXT_CONTROL_TABLE_DEFINES_SVH
`define UE_CONTEXT_CONTROL_TABLE_DEFINES_SVH

// Same-cycle implication, held off during reset.
`define UCCT_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("ucct check failed");

// Next-cycle implication, held off during reset.
`define UCCT_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("ucct check failed");

`endif

// File: src/ucct_pkg.sv
package ucct_pkg;

    localparam logic [3:0] OP_SETUP_REQ  = 4'd0;
    localparam logic [3:0] OP_SETUP_DONE = 4'd1;
    localparam logic [3:0] OP_RELEASE    = 4'd2;
    localparam logic [3:0] OP_RESUME_REQ = 4'd3;
    localparam logic [3:0] OP_REEST_REQ  = 4'd4;
    localparam logic [3:0] OP_SUSPEND    = 4'd5;
    localparam logic [3:0] OP_REACTIVATE = 4'd6;
    localparam logic [3:0] OP_ADMIT      = 4'd7;
    localparam logic [3:0] OP_REMOVE     = 4'd8;

    localparam logic [2:0] KIND_SETUP       = 3'd0;
    localparam logic [2:0] KIND_SUSP_REL    = 3'd1;
    localparam logic [2:0] KIND_RESUME_OK   = 3'd2;
    localparam logic [2:0] KIND_RESUME_FAIL = 3'd3;
    localparam logic [2:0] KIND_REEST_OK    = 3'd4;
    localparam logic [2:0] KIND_REEST_FAIL  = 3'd5;
    localparam logic [2:0] KIND_TABLE_FULL  = 3'd6;

    localparam logic [1:0] MODE_IDLE       = 2'd0;
    localparam logic [1:0] MODE_CONNECTING = 2'd1;
    localparam logic [1:0] MODE_CONNECTED  = 2'd2;
    localparam logic [1:0] MODE_INACTIVE   = 2'd3;

    localparam logic [16:0] WINDOW_SPAN = 17'h2000;
    localparam int          REL_SUSPEND_BIT = 1;

    localparam logic [1:0] REG_OWN_CELL    = 2'd0;
    localparam logic [1:0] REG_WINDOW_BASE = 2'd1;
    localparam logic [1:0] REG_FIRST_ALLOC = 2'd2;

    typedef struct packed {
        logic [3:0]  operation;
        logic [15:0] ue_id;
        logic [15:0] cell_or_old_id;
        logic [7:0]  release_flags;
        logic [31:0] resume_identity;
    } t_item;

    typedef struct packed {
        logic [2:0]  reply_kind;
        logic [15:0] dest_id;
        logic [15:0] assigned_id;
        logic [31:0] resume_out;
        logic [15:0] old_id;
        logic        migrate;
        logic        suspend_notice;
    } t_result;

    typedef struct packed {
        logic [15:0] key;
        logic [1:0]  mode;
        logic [31:0] resume;
    } t_entry;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

endpackage

// File: src/ucct_ram.sv
module ucct_ram #(
    parameter int WIDTH = 50,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: src/ucct_front.sv
module ucct_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  ucct_pkg::t_item    i_item,
    input  logic [15:0]        i_own_cell_id,
    input  logic [15:0]        i_id_window_base,
    output logic               o_busy,
    input  logic               i_pop,
    output ucct_pkg::t_item    o_q_item,
    output ucct_pkg::t_q_status o_q_status
);

    ucct_pkg::t_item r_q [2];
    logic            r_wptr;
    logic            r_rptr;
    logic [1:0]      r_cnt;
    logic            keep;
    logic            push;
    logic [16:0]     owner;
    logic [16:0]     base;

    assign owner = {1'b0, i_item.resume_identity[31:16]};
    assign base  = {1'b0, i_id_window_base};

    // Drop foreign setups, foreign resumes and undefined codes here.
    always_comb begin
        case (i_item.operation)
            ucct_pkg::OP_SETUP_REQ:
                keep = (i_item.cell_or_old_id == 16'd0) ||
                       (i_item.cell_or_old_id == i_own_cell_id);
            ucct_pkg::OP_RESUME_REQ:
                keep = (owner >= base) && (owner < base + ucct_pkg::WINDOW_SPAN);
            ucct_pkg::OP_SETUP_DONE, ucct_pkg::OP_RELEASE, ucct_pkg::OP_REEST_REQ,
            ucct_pkg::OP_SUSPEND, ucct_pkg::OP_REACTIVATE, ucct_pkg::OP_ADMIT,
            ucct_pkg::OP_REMOVE:
                keep = 1'b1;
            default:
                keep = 1'b0;
        endcase
    end

    assign o_busy = (r_cnt == 2'd2);
    assign push   = i_start && !o_busy && keep;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= 1'b0;
            r_rptr <= 1'b0;
            r_cnt  <= 2'd0;
        end else begin
            if (push) begin
                r_q[r_wptr] <= i_item;
                r_wptr      <= !r_wptr;
            end
            if (i_pop) begin
                r_rptr <= !r_rptr;
            end
            r_cnt <= r_cnt + 2'(push) - 2'(i_pop);
        end
    end

    assign o_q_item         = r_q[r_rptr];
    assign o_q_status.full  = (r_cnt == 2'd2);
    assign o_q_status.empty = (r_cnt == 2'd0);

endmodule

// File: src/ucct_back.sv
module ucct_back #(
    parameter int TABLE_DEPTH = 64
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  ucct_pkg::t_item     i_q_item,
    input  ucct_pkg::t_q_status i_q_status,
    output logic                o_pop,
    input  logic                i_alloc_load,
    input  logic [15:0]         i_alloc_value,
    output logic                o_valid,
    output ucct_pkg::t_result   o_result
);

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam logic [AW-1:0] LAST = AW'(TABLE_DEPTH - 1);
    localparam int EW = $bits(ucct_pkg::t_entry);

    typedef enum logic [1:0] {S_IDLE, S_SCAN, S_APPLY} t_state;

    t_state            r_state;
    ucct_pkg::t_item   r_item;
    logic [15:0]       r_k1;
    logic [15:0]       r_newid;
    logic              r_use_alloc;
    logic [15:0]       r_next_alloc;
    logic [15:0]       r_resume_seq;
    logic              r_valid [TABLE_DEPTH];
    logic [AW-1:0]     r_addr;
    logic              r_issued;
    logic              r_rd_v;
    logic [AW-1:0]     r_rd_idx;
    logic              r_m1_found;
    logic [AW-1:0]     r_m1_idx;
    ucct_pkg::t_entry  r_m1_ent;
    logic              r_m2_found;
    logic [AW-1:0]     r_m2_idx;
    logic              r_free_found;
    logic [AW-1:0]     r_free_idx;
    logic              r_rs_found;
    logic [AW-1:0]     r_rs_idx;
    logic [15:0]       r_rs_key;
    logic              r_out_valid;
    ucct_pkg::t_result r_out;

    logic [EW-1:0]     rd_raw;
    ucct_pkg::t_entry  rd_ent;
    logic              rd_live;
    logic [15:0]       q_newid;
    logic [15:0]       q_k1;
    logic              wr_en;
    logic [AW-1:0]     wr_addr;
    ucct_pkg::t_entry  wr_ent;
    logic              set_en;
    logic              clr_en;
    logic [AW-1:0]     clr_idx;
    logic              alloc_inc;
    logic              seq_inc;
    logic              res_en;
    ucct_pkg::t_result res;
    logic [31:0]       susp_rid;
    logic              susp_ok;

    ucct_ram #(.WIDTH(EW), .DEPTH(TABLE_DEPTH)) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_ent),
        .i_rd_addr (r_addr),
        .o_rd_data (rd_raw)
    );

    assign rd_ent  = ucct_pkg::t_entry'(rd_raw);
    assign rd_live = r_valid[r_rd_idx];
    assign o_pop   = (r_state == S_IDLE) && !i_q_status.empty;

    assign q_newid = (i_q_item.ue_id != 16'd0) ? i_q_item.ue_id : r_next_alloc;
    always_comb begin
        case (i_q_item.operation)
            ucct_pkg::OP_SETUP_REQ: q_k1 = q_newid;
            ucct_pkg::OP_REEST_REQ: q_k1 = i_q_item.cell_or_old_id;
            default:                q_k1 = i_q_item.ue_id;
        endcase
    end

    assign susp_rid = {r_item.ue_id, r_resume_seq};
    assign susp_ok  = r_m1_found && (r_m1_ent.mode == ucct_pkg::MODE_CONNECTED);

    // Decide the table update and the reply from the scan results.
    always_comb begin
        wr_en     = 1'b0;
        wr_addr   = r_m1_idx;
        wr_ent    = r_m1_ent;
        set_en    = 1'b0;
        clr_en    = 1'b0;
        clr_idx   = r_m1_idx;
        alloc_inc = 1'b0;
        seq_inc   = 1'b0;
        res_en    = 1'b0;
        res       = '0;
        if (r_state == S_APPLY) begin
            case (r_item.operation)
                ucct_pkg::OP_SETUP_REQ, ucct_pkg::OP_ADMIT: begin
                    if (!r_m1_found && !r_free_found) begin
                        res_en          = 1'b1;
                        res.reply_kind  = ucct_pkg::KIND_TABLE_FULL;
                        res.dest_id     = r_k1;
                    end else begin
                        wr_en       = 1'b1;
                        set_en      = 1'b1;
                        wr_addr     = r_m1_found ? r_m1_idx : r_free_idx;
                        wr_ent.key  = r_k1;
                        wr_ent.resume = 32'd0;
                        if (r_item.operation == ucct_pkg::OP_SETUP_REQ) begin
                            wr_ent.mode     = ucct_pkg::MODE_CONNECTING;
                            alloc_inc       = r_use_alloc;
                            res_en          = 1'b1;
                            res.reply_kind  = ucct_pkg::KIND_SETUP;
                            res.dest_id     = r_k1;
                            res.assigned_id = r_k1;
                        end else begin
                            wr_ent.mode = ucct_pkg::MODE_CONNECTED;
                        end
                    end
                end
                ucct_pkg::OP_SETUP_DONE: begin
                    wr_en       = r_m1_found;
                    wr_ent.mode = ucct_pkg::MODE_CONNECTED;
                end
                ucct_pkg::OP_RELEASE, ucct_pkg::OP_SUSPEND: begin
                    if ((r_item.operation == ucct_pkg::OP_SUSPEND) ||
                        r_item.release_flags[ucct_pkg::REL_SUSPEND_BIT]) begin
                        if (susp_ok) begin
                            wr_en              = 1'b1;
                            wr_ent.mode        = ucct_pkg::MODE_INACTIVE;
                            wr_ent.resume      = susp_rid;
                            seq_inc            = 1'b1;
                            res_en             = 1'b1;
                            res.reply_kind     = ucct_pkg::KIND_SUSP_REL;
                            res.dest_id        = r_item.ue_id;
                            res.resume_out     = susp_rid;
                            res.suspend_notice = 1'b1;
                        end
                    end else begin
                        wr_en       = r_m1_found;
                        wr_ent.mode = ucct_pkg::MODE_IDLE;
                    end
                end
                ucct_pkg::OP_RESUME_REQ: begin
                    res_en = 1'b1;
                    if (!r_rs_found) begin
                        res.reply_kind = ucct_pkg::KIND_RESUME_FAIL;
                        res.dest_id    = r_item.ue_id;
                    end else begin
                        wr_en           = 1'b1;
                        wr_addr         = r_rs_idx;
                        wr_ent.key      = r_newid;
                        wr_ent.mode     = ucct_pkg::MODE_CONNECTED;
                        wr_ent.resume   = 32'd0;
                        clr_en          = r_m2_found && (r_m2_idx != r_rs_idx);
                        clr_idx         = r_m2_idx;
                        alloc_inc       = r_use_alloc;
                        res.reply_kind  = ucct_pkg::KIND_RESUME_OK;
                        res.dest_id     = r_newid;
                        res.assigned_id = r_newid;
                        res.old_id      = r_rs_key;
                        res.migrate     = 1'b1;
                    end
                end
                ucct_pkg::OP_REEST_REQ: begin
                    res_en = 1'b1;
                    if ((r_k1 == 16'd0) || !susp_ok) begin
                        res.reply_kind = ucct_pkg::KIND_REEST_FAIL;
                        res.dest_id    = r_item.ue_id;
                    end else begin
                        wr_en           = 1'b1;
                        wr_ent.key      = r_newid;
                        clr_en          = r_m2_found && (r_m2_idx != r_m1_idx);
                        clr_idx         = r_m2_idx;
                        alloc_inc       = r_use_alloc;
                        res.reply_kind  = ucct_pkg::KIND_REEST_OK;
                        res.dest_id     = r_newid;
                        res.assigned_id = r_newid;
                        res.old_id      = r_k1;
                        res.migrate     = 1'b1;
                    end
                end
                ucct_pkg::OP_REACTIVATE: begin
                    if (r_m1_found && (r_m1_ent.mode == ucct_pkg::MODE_INACTIVE)) begin
                        wr_en         = 1'b1;
                        wr_ent.mode   = ucct_pkg::MODE_CONNECTED;
                        wr_ent.resume = 32'd0;
                    end
                end
                ucct_pkg::OP_REMOVE: begin
                    clr_en = r_m1_found;
                end
                default: begin
                    res_en = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_next_alloc <= 16'd0;
            r_resume_seq <= 16'd0;
            r_out_valid  <= 1'b0;
            r_rd_v       <= 1'b0;
            for (int i = 0; i < TABLE_DEPTH; i++) begin
                r_valid[i] <= 1'b0;
            end
        end else begin
            r_out_valid <= 1'b0;
            if (i_alloc_load) begin
                r_next_alloc <= i_alloc_value;
            end else if (alloc_inc) begin
                r_next_alloc <= r_next_alloc + 16'd1;
            end
            if (seq_inc) begin
                r_resume_seq <= r_resume_seq + 16'd1;
            end
            case (r_state)
                S_IDLE: begin
                    r_rd_v <= 1'b0;
                    if (!i_q_status.empty) begin
                        r_item       <= i_q_item;
                        r_k1         <= q_k1;
                        r_newid      <= q_newid;
                        r_use_alloc  <= (i_q_item.ue_id == 16'd0);
                        r_addr       <= '0;
                        r_issued     <= 1'b0;
                        r_m1_found   <= 1'b0;
                        r_m2_found   <= 1'b0;
                        r_free_found <= 1'b0;
                        r_rs_found   <= 1'b0;
                        r_state      <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    r_rd_v   <= !r_issued;
                    r_rd_idx <= r_addr;
                    if (r_addr == LAST) begin
                        r_issued <= 1'b1;
                    end else begin
                        r_addr <= r_addr + AW'(1);
                    end
                    if (r_rd_v) begin
                        if (rd_live && (rd_ent.key == r_k1) && !r_m1_found) begin
                            r_m1_found <= 1'b1;
                            r_m1_idx   <= r_rd_idx;
                            r_m1_ent   <= rd_ent;
                        end
                        if (rd_live && (rd_ent.key == r_newid) && !r_m2_found) begin
                            r_m2_found <= 1'b1;
                            r_m2_idx   <= r_rd_idx;
                        end
                        if (!rd_live && !r_free_found) begin
                            r_free_found <= 1'b1;
                            r_free_idx   <= r_rd_idx;
                        end
                        // Keep the inactive match with the smallest key.
                        if (rd_live && (rd_ent.mode == ucct_pkg::MODE_INACTIVE) &&
                            (rd_ent.resume == r_item.resume_identity) &&
                            (!r_rs_found || (rd_ent.key < r_rs_key))) begin
                            r_rs_found <= 1'b1;
                            r_rs_idx   <= r_rd_idx;
                            r_rs_key   <= rd_ent.key;
                        end
                        if (r_rd_idx == LAST) begin
                            r_state <= S_APPLY;
                        end
                    end
                end
                S_APPLY: begin
                    r_rd_v <= 1'b0;
                    if (set_en) begin
                        r_valid[wr_addr] <= 1'b1;
                    end
                    if (clr_en) begin
                        r_valid[clr_idx] <= 1'b0;
                    end
                    r_out_valid <= res_en;
                    r_out       <= res;
                    r_state     <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_valid  = r_out_valid;
    assign o_result = r_out;

endmodule

// File: src/ue_context_control_table.sv
// Terminal context table with a command-style item port and an APB-style register port.
// An item is taken at a clock edge where start is high and busy is low. A small
// front queue (two items) classifies items and drops foreign setups, foreign
// resumes and undefined codes; busy is high only while that queue is full.
// The back end pops one item, scans every table slot through the single read
// port of the context RAM, then applies one update. The scan takes most of
// the time per item, and the back end takes no new item until that update is
// applied. The result, if any, shows on o_result for exactly one cycle
// with o_valid high, in the cycle after the update; the receiver cannot stall it.
// Registers: own cell id at 0x0, id window base at 0x4, first allocated id at
// 0x8 (a write loads the allocator). Write registers only while idle.
// Synchronous reset clears the queue, all valid bits, the allocator and the
// resume sequence; stored entries stay undefined until written.
`include "ue_context_control_table_defines.svh"

module ue_context_control_table #(
    parameter int TABLE_DEPTH = 64
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  ucct_pkg::t_item   i_item,
    output logic              o_valid,
    output ucct_pkg::t_result o_result,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [3:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    logic [15:0]         r_own_cell_id;
    logic [15:0]         r_id_window_base;
    logic [15:0]         r_first_alloc_id;
    logic                cfg_wr;
    logic                alloc_load;
    logic                pop;
    ucct_pkg::t_item     q_item;
    ucct_pkg::t_q_status q_status;

    assign pready     = 1'b1;
    assign cfg_wr     = psel && penable && pwrite && pready;
    assign alloc_load = cfg_wr && (paddr[3:2] == ucct_pkg::REG_FIRST_ALLOC);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_own_cell_id    <= 16'd0;
            r_id_window_base <= 16'd0;
            r_first_alloc_id <= 16'd0;
        end else if (cfg_wr) begin
            case (paddr[3:2])
                ucct_pkg::REG_OWN_CELL:    r_own_cell_id    <= pwdata[15:0];
                ucct_pkg::REG_WINDOW_BASE: r_id_window_base <= pwdata[15:0];
                ucct_pkg::REG_FIRST_ALLOC: r_first_alloc_id <= pwdata[15:0];
                default:                   r_own_cell_id    <= r_own_cell_id;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            ucct_pkg::REG_OWN_CELL:    prdata = {16'd0, r_own_cell_id};
            ucct_pkg::REG_WINDOW_BASE: prdata = {16'd0, r_id_window_base};
            ucct_pkg::REG_FIRST_ALLOC: prdata = {16'd0, r_first_alloc_id};
            default:                   prdata = 32'd0;
        endcase
    end

    ucct_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_start          (start),
        .i_item           (i_item),
        .i_own_cell_id    (r_own_cell_id),
        .i_id_window_base (r_id_window_base),
        .o_busy           (busy),
        .i_pop            (pop),
        .o_q_item         (q_item),
        .o_q_status       (q_status)
    );

    ucct_back #(.TABLE_DEPTH(TABLE_DEPTH)) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_item      (q_item),
        .i_q_status    (q_status),
        .o_pop         (pop),
        .i_alloc_load  (alloc_load),
        .i_alloc_value (pwdata[15:0]),
        .o_valid       (o_valid),
        .o_result      (o_result)
    );

    `UCCT_ASSERT_NEXT(a_result_spaced, o_valid, !o_valid)
    `UCCT_ASSERT_NOW(a_queue_sane, 1'b1, !(q_status.full && q_status.empty))
    `UCCT_ASSERT_NOW(a_pop_nonempty, pop, !q_status.empty)
    `UCCT_ASSERT_NOW(a_migrate_kind, o_valid && o_result.migrate,
        (o_result.reply_kind == ucct_pkg::KIND_RESUME_OK) ||
        (o_result.reply_kind == ucct_pkg::KIND_REEST_OK))

endmodule

// File: test/ue_context_control_table_tb.sv
`timescale 1ns / 100ps

import ucct_pkg::*;

class ctx_scoreboard;
    localparam int DEPTH = 64;

    logic [15:0] own_cell;
    logic [15:0] win_base;
    logic        ent_valid [DEPTH];
    logic [15:0] ent_key [DEPTH];
    logic [1:0]  ent_mode [DEPTH];
    logic [31:0] ent_resume [DEPTH];
    logic [15:0] alloc_id;
    logic [15:0] seq_num;
    t_result     pending_replies[$];
    int          errors;

    function void clear();
        own_cell = '0;
        win_base = '0;
        alloc_id = '0;
        seq_num = '0;
        errors = 0;
        foreach (ent_valid[i]) ent_valid[i] = 1'b0;
    endfunction

    function int find_key(logic [15:0] k);
        for (int i = 0; i < DEPTH; i++)
            if (ent_valid[i] && ent_key[i] == k) return i;
        return -1;
    endfunction

    function int find_free();
        for (int i = 0; i < DEPTH; i++)
            if (!ent_valid[i]) return i;
        return -1;
    endfunction

    function logic [15:0] take_id(logic [15:0] ue);
        if (ue != 0) return ue;
        alloc_id = alloc_id + 16'd1;
        return alloc_id - 16'd1;
    endfunction

    function void rekey(int slot, logic [15:0] k);
        int other;
        other = find_key(k);
        if (other >= 0 && other != slot) ent_valid[other] = 1'b0;
        ent_key[slot] = k;
    endfunction

    function bit put_entry(logic [15:0] k, logic [1:0] m);
        int s;
        s = find_key(k);
        if (s < 0) s = find_free();
        if (s < 0) return 0;
        ent_valid[s] = 1'b1;
        ent_key[s] = k;
        ent_mode[s] = m;
        ent_resume[s] = '0;
        return 1;
    endfunction

    function void suspend_ctx(logic [15:0] id);
        int s;
        t_result r;
        s = find_key(id);
        if (s < 0 || ent_mode[s] != MODE_CONNECTED) return;
        r = '0;
        r.reply_kind = KIND_SUSP_REL;
        r.dest_id = id;
        r.resume_out = {id, seq_num};
        r.suspend_notice = 1'b1;
        seq_num = seq_num + 16'd1;
        ent_mode[s] = MODE_INACTIVE;
        ent_resume[s] = r.resume_out;
        pending_replies.push_back(r);
    endfunction

    // Apply one accepted item and queue the reply it causes, if any.
    function void note_item(t_item it);
        int s;
        logic [15:0] id;
        logic [16:0] owner;
        t_result r;
        r = '0;
        case (it.operation)
            OP_SETUP_REQ: begin
                if (it.cell_or_old_id != 0 && it.cell_or_old_id != own_cell) return;
                id = (it.ue_id != 0) ? it.ue_id : alloc_id;
                if (find_key(id) < 0 && find_free() < 0) begin
                    r.reply_kind = KIND_TABLE_FULL;
                    r.dest_id = id;
                end else begin
                    id = take_id(it.ue_id);
                    void'(put_entry(id, MODE_CONNECTING));
                    r.reply_kind = KIND_SETUP;
                    r.dest_id = id;
                    r.assigned_id = id;
                end
                pending_replies.push_back(r);
            end
            OP_SETUP_DONE: begin
                s = find_key(it.ue_id);
                if (s >= 0) ent_mode[s] = MODE_CONNECTED;
            end
            OP_RELEASE: begin
                if (it.release_flags[REL_SUSPEND_BIT]) begin
                    suspend_ctx(it.ue_id);
                end else begin
                    s = find_key(it.ue_id);
                    if (s >= 0) ent_mode[s] = MODE_IDLE;
                end
            end
            OP_RESUME_REQ: begin
                owner = {1'b0, it.resume_identity[31:16]};
                if (owner < {1'b0, win_base} || owner >= {1'b0, win_base} + WINDOW_SPAN)
                    return;
                s = -1;
                for (int i = 0; i < DEPTH; i++)
                    if (ent_valid[i] && ent_mode[i] == MODE_INACTIVE &&
                        ent_resume[i] == it.resume_identity &&
                        (s < 0 || ent_key[i] < ent_key[s]))
                        s = i;
                if (s < 0) begin
                    r.reply_kind = KIND_RESUME_FAIL;
                    r.dest_id = it.ue_id;
                end else begin
                    r.old_id = ent_key[s];
                    id = take_id(it.ue_id);
                    ent_mode[s] = MODE_CONNECTED;
                    ent_resume[s] = '0;
                    rekey(s, id);
                    r.reply_kind = KIND_RESUME_OK;
                    r.dest_id = id;
                    r.assigned_id = id;
                    r.migrate = 1'b1;
                end
                pending_replies.push_back(r);
            end
            OP_REEST_REQ: begin
                s = (it.cell_or_old_id != 0) ? find_key(it.cell_or_old_id) : -1;
                if (s < 0 || ent_mode[s] != MODE_CONNECTED) begin
                    r.reply_kind = KIND_REEST_FAIL;
                    r.dest_id = it.ue_id;
                end else begin
                    id = take_id(it.ue_id);
                    rekey(s, id);
                    r.reply_kind = KIND_REEST_OK;
                    r.dest_id = id;
                    r.assigned_id = id;
                    r.old_id = it.cell_or_old_id;
                    r.migrate = 1'b1;
                end
                pending_replies.push_back(r);
            end
            OP_SUSPEND: suspend_ctx(it.ue_id);
            OP_REACTIVATE: begin
                s = find_key(it.ue_id);
                if (s >= 0 && ent_mode[s] == MODE_INACTIVE) begin
                    ent_mode[s] = MODE_CONNECTED;
                    ent_resume[s] = '0;
                end
            end
            OP_ADMIT: begin
                if (!put_entry(it.ue_id, MODE_CONNECTED)) begin
                    r.reply_kind = KIND_TABLE_FULL;
                    r.dest_id = it.ue_id;
                    pending_replies.push_back(r);
                end
            end
            OP_REMOVE: begin
                s = find_key(it.ue_id);
                if (s >= 0) ent_valid[s] = 1'b0;
            end
            default: ;
        endcase
    endfunction

    function void check_reply(t_result act);
        t_result want;
        if (pending_replies.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected reply %p", act);
            return;
        end
        want = pending_replies.pop_front();
        if (act !== want) begin
            errors++;
            if (errors <= 10) $display("reply mismatch: expected %p actual %p", want, act);
        end
    endfunction
endclass

module ue_context_control_table_tb;
    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    t_item       i_item = '0;
    logic        o_valid;
    t_result     o_result;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    ctx_scoreboard ctx_sb;
    bit            gaps_on;

    ue_context_control_table uut (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    initial begin
        #10_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    always @(posedge i_clk)
        if (i_rst_n && o_valid) ctx_sb.check_reply(o_result);

    function int gap_len();
        if (!gaps_on) return 0;
        if ($urandom_range(0, 9) < 8) return $urandom_range(0, 2);
        return $urandom_range(10, 40);
    endfunction

    // Each task starts and ends just after a falling edge.
    task automatic send(t_item it);
        int g;
        start = 1'b1;
        i_item = it;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        ctx_sb.note_item(it);
        @(negedge i_clk);
        g = gap_len();
        if (g > 0) begin
            start = 1'b0;
            i_item = t_item'({$urandom, $urandom, $urandom});
            repeat (g - 1) @(negedge i_clk);
        end
    endtask

    task automatic send_op(logic [3:0] op, logic [15:0] ue, logic [15:0] tgt,
                           logic [7:0] flags, logic [31:0] rid);
        t_item it;
        it.operation = op;
        it.ue_id = ue;
        it.cell_or_old_id = tgt;
        it.release_flags = flags;
        it.resume_identity = rid;
        send(it);
    endtask

    task automatic drain();
        start = 1'b0;
        while (ctx_sb.pending_replies.size() != 0) @(negedge i_clk);
        repeat (400) @(negedge i_clk);
    endtask

    task automatic reg_write(logic [1:0] idx, logic [15:0] val);
        psel = 1'b1;
        penable = 1'b0;
        pwrite = 1'b1;
        paddr = {idx, 2'b00};
        pwdata = {16'($urandom_range(0, 65535)), val};
        @(negedge i_clk);
        penable = 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        case (idx)
            REG_OWN_CELL: ctx_sb.own_cell = val;
            REG_WINDOW_BASE: ctx_sb.win_base = val;
            default: ctx_sb.alloc_id = val;
        endcase
        @(negedge i_clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
    endtask

    task automatic set_config(logic [15:0] own, logic [15:0] base, logic [15:0] first);
        reg_write(REG_OWN_CELL, own);
        reg_write(REG_WINDOW_BASE, base);
        reg_write(REG_FIRST_ALLOC, first);
    endtask

    // Mostly a live key, else an id in the window, else anything.
    function logic [15:0] pick_id(int want_mode);
        int slots[$];
        int n;
        for (int i = 0; i < ctx_sb.DEPTH; i++)
            if (ctx_sb.ent_valid[i] && (want_mode < 0 || ctx_sb.ent_mode[i] == want_mode))
                slots.push_back(i);
        n = $urandom_range(0, 9);
        if (slots.size() != 0 && n < 6)
            return ctx_sb.ent_key[slots[$urandom_range(0, slots.size() - 1)]];
        if (n < 9) return ctx_sb.win_base + 16'($urandom_range(0, 63));
        return 16'($urandom);
    endfunction

    function logic [31:0] pick_rid();
        int slots[$];
        int n;
        for (int i = 0; i < ctx_sb.DEPTH; i++)
            if (ctx_sb.ent_valid[i] && ctx_sb.ent_mode[i] == MODE_INACTIVE)
                slots.push_back(i);
        n = $urandom_range(0, 9);
        if (slots.size() != 0 && n < 7)
            return ctx_sb.ent_resume[slots[$urandom_range(0, slots.size() - 1)]];
        if (n < 9) return {ctx_sb.win_base + 16'($urandom_range(0, 8191)), 16'($urandom)};
        return $urandom;
    endfunction

    function logic [15:0] new_ue();
        return ($urandom_range(0, 3) == 0) ? 16'd0 : pick_id(-1);
    endfunction

    task automatic random_item();
        int sel;
        int live;
        logic [15:0] tgt_cell;
        live = 0;
        foreach (ctx_sb.ent_valid[i]) live += ctx_sb.ent_valid[i];
        sel = $urandom_range(0, 99);
        if (live > 40 && sel < 20) begin
            send_op(OP_REMOVE, pick_id(-1), 16'($urandom), 8'($urandom), $urandom);
        end else if (sel < 20) begin
            case ($urandom_range(0, 3))
                0: tgt_cell = 16'd0;
                1: tgt_cell = 16'($urandom);
                default: tgt_cell = ctx_sb.own_cell;
            endcase
            send_op(OP_SETUP_REQ, new_ue(), tgt_cell, 8'($urandom), $urandom);
        end else if (sel < 35) begin
            send_op(OP_SETUP_DONE, pick_id(MODE_CONNECTING), 16'($urandom), 8'($urandom),
                    $urandom);
        end else if (sel < 47) begin
            send_op(OP_RELEASE, pick_id(MODE_CONNECTED), 16'($urandom), 8'($urandom),
                    $urandom);
        end else if (sel < 57) begin
            send_op(OP_SUSPEND, pick_id(MODE_CONNECTED), 16'($urandom), 8'($urandom),
                    $urandom);
        end else if (sel < 72) begin
            send_op(OP_RESUME_REQ, new_ue(), 16'($urandom), 8'($urandom), pick_rid());
        end else if (sel < 82) begin
            send_op(OP_REEST_REQ, new_ue(),
                    ($urandom_range(0, 9) == 0) ? 16'd0 : pick_id(MODE_CONNECTED),
                    8'($urandom), $urandom);
        end else if (sel < 87) begin
            send_op(OP_REACTIVATE, pick_id(MODE_INACTIVE), 16'($urandom), 8'($urandom),
                    $urandom);
        end else if (sel < 93) begin
            send_op(OP_ADMIT, ($urandom_range(0, 9) == 0) ? 16'd0 : pick_id(-1),
                    16'($urandom), 8'($urandom), $urandom);
        end else if (sel < 97) begin
            send_op(OP_REMOVE, pick_id(-1), 16'($urandom), 8'($urandom), $urandom);
        end else begin
            send_op(4'($urandom_range(9, 15)), 16'($urandom), 16'($urandom), 8'($urandom),
                    $urandom);
        end
    endtask

    task automatic empty_table();
        logic [15:0] keys[$];
        foreach (ctx_sb.ent_valid[i])
            if (ctx_sb.ent_valid[i]) keys.push_back(ctx_sb.ent_key[i]);
        foreach (keys[i]) send_op(OP_REMOVE, keys[i], '0, '0, '0);
    endtask

    task automatic random_phase(int count);
        for (int i = 0; i < count; i++) begin
            if (i % 60 == 0) gaps_on = ($urandom_range(0, 3) != 0);
            random_item();
        end
        gaps_on = 1'b1;
    endtask

    initial begin
        ctx_sb = new();
        ctx_sb.clear();
        gaps_on = 1'b1;
        repeat (2) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        set_config(16'h1234, 16'h4000, 16'h4000);
        send_op(OP_SETUP_REQ, 16'h0000, 16'h0000, 8'h00, 32'h0);
        send_op(OP_SETUP_REQ, 16'h4005, 16'h1234, 8'h00, 32'h0);
        send_op(OP_SETUP_REQ, 16'h1111, 16'h9999, 8'h00, 32'h0);
        send_op(OP_SETUP_DONE, 16'h4000, 16'h0, 8'h00, 32'h0);
        send_op(OP_SETUP_DONE, 16'h4005, 16'h0, 8'h00, 32'h0);
        send_op(OP_RELEASE, 16'h4005, 16'h0, 8'h02, 32'h0);
        send_op(OP_RESUME_REQ, 16'h0000, 16'h0, 8'h00, 32'h4005_0000);
        send_op(OP_RESUME_REQ, 16'h4010, 16'h0, 8'h00, 32'h1234_0000);
        send_op(OP_RESUME_REQ, 16'h4011, 16'h0, 8'h00, 32'h4000_0099);
        send_op(OP_REEST_REQ, 16'h4001, 16'h4000, 8'h00, 32'h0);
        send_op(OP_REEST_REQ, 16'hFFFF, 16'h0000, 8'h00, 32'h0);
        send_op(OP_SUSPEND, 16'h4001, 16'h0, 8'h00, 32'h0);
        send_op(OP_REACTIVATE, 16'h4001, 16'h0, 8'h00, 32'h0);
        send_op(OP_RELEASE, 16'h4001, 16'h0, 8'hFD, 32'h0);
        send_op(OP_SUSPEND, 16'h4001, 16'h0, 8'h00, 32'h0);
        send_op(OP_ADMIT, 16'h0000, 16'h0, 8'h00, 32'h0);
        send_op(OP_REMOVE, 16'hBEEF, 16'h0, 8'h00, 32'h0);
        send_op(OP_SETUP_DONE, 16'hBEEF, 16'h0, 8'h00, 32'h0);
        send_op(4'd9, 16'h0, 16'h0, 8'h00, 32'h0);
        send_op(4'd15, 16'hFFFF, 16'hFFFF, 8'hFF, 32'hFFFF_FFFF);
        send_op(OP_REMOVE, 16'h0000, 16'h0, 8'h00, 32'h0);

        // fill the table, then overflow it from both setup and admit
        for (int i = 0; i < 64; i++)
            send_op(OP_ADMIT, 16'h5000 + 16'(i), 16'h0, 8'h00, 32'h0);
        send_op(OP_SETUP_REQ, 16'h6000, 16'h0, 8'h00, 32'h0);
        send_op(OP_SETUP_REQ, 16'h0000, 16'h1234, 8'h00, 32'h0);
        send_op(OP_ADMIT, 16'h6001, 16'h0, 8'h00, 32'h0);
        send_op(OP_ADMIT, 16'h5003, 16'h0, 8'h00, 32'h0);
        empty_table();
        random_phase(250);
        drain();

        set_config(16'h0000, 16'h0000, 16'h0000);
        random_phase(250);
        drain();

        set_config(16'hFFFF, 16'hE000, 16'hFFFE);
        random_phase(250);
        drain();

        set_config(16'h0001, 16'hFFFF, 16'hFFFF);
        random_phase(250);
        drain();

        ctx_sb.errors += ctx_sb.pending_replies.size();
        if (ctx_sb.errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end
endmodule
